/* hdl/sfr_pkg.sv */
package sfr_pkg;

  localparam int unsigned REG_BYTES  = 16;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN  = 3'd5;

  typedef struct packed {
    logic [8*REG_BYTES-1:0] pattern;
    logic [LEN_W-1:0]       pattern_length;
    logic [8*REG_BYTES-1:0] replacement;
    logic [LEN_W-1:0]       replacement_length;
  } sfr_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_window;
    logic emit_repl;
    logic clear;
    logic finish;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic prefix;
    logic count_zero;
    logic repl_done;
    logic emit_ok;
    logic finish_ok;
    logic in_present;
    logic in_end;
    logic end_q;
  } sfr_sts_t;

endpackage

/* hdl/sfr_if.sv */
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       end_of_stream;

  modport source (output valid, in_byte, byte_present, end_of_stream, input ready);
  modport sink   (input valid, in_byte, byte_present, end_of_stream, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, out_byte, has_byte, run_last, stream_done, input ready);
  modport sink   (input valid, out_byte, has_byte, run_last, stream_done, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/sfr_cfg_regs.sv */
module sfr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sfr_pkg::sfr_cfg_t              cfg_o,
  output logic                           pat_wr_o
);
  import sfr_pkg::*;

  sfr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                    <= '0;
      cfg_q.pattern_length     <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PATTERN_LOW:      cfg_q.pattern[63:0]            <= cfg_data_i;
        REG_PATTERN_HIGH:     cfg_q.pattern[127:64]          <= cfg_data_i;
        REG_PATTERN_LENGTH:   cfg_q.pattern_length           <= cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT_LOW:  cfg_q.replacement[63:0]        <= cfg_data_i;
        REG_REPLACEMENT_HIGH: cfg_q.replacement[127:64]      <= cfg_data_i;
        REG_REPLACEMENT_LEN:  cfg_q.replacement_length       <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // any pattern change drops the held bytes
  assign pat_wr_o = cfg_valid_i &&
                    (cfg_index_i inside {REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH});
  assign cfg_o    = cfg_q;

endmodule

/* hdl/sfr_datapath.sv */
module sfr_datapath #(
  parameter int unsigned PAT_CAP = 16,
  parameter int unsigned REP_CAP = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::sfr_cfg_t cfg_i,
  input  logic              pat_wr_i,
  input  logic [7:0]        in_byte_i,
  input  logic              byte_present_i,
  input  logic              end_of_stream_i,
  input  sfr_pkg::sfr_cmd_t cmd_i,
  output sfr_pkg::sfr_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              run_last_o,
  output logic              stream_done_o
);
  import sfr_pkg::*;

  localparam int unsigned CW = $clog2(PAT_CAP + 1);
  localparam int unsigned IW = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
  localparam int unsigned RW = $clog2(REP_CAP + 2);

  logic [7:0]       win_q [PAT_CAP];
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    plen;
  logic [CW-1:0]    app_cnt;
  logic [IW-1:0]    app_idx;
  logic [LEN_W-1:0] plen_full;
  logic [LEN_W-1:0] rlen_full;
  logic [RW-1:0]    rlen;
  logic [RW-1:0]    rep_idx_q;
  logic [3:0]       rep_sel;
  logic [7:0]       rep_byte;
  logic [7:0]       new_byte;
  logic             prefix;
  logic             emit;
  logic             end_q;
  logic             hold_vld_q;
  logic [7:0]       hold_byte_q;
  logic             out_vld_q;
  logic             out_free;
  logic             push_hold;
  logic             push_last;

  // effective lengths: pattern 1..PAT_CAP, replacement 0..REP_CAP
  always_comb begin
    plen_full = cfg_i.pattern_length;
    if (plen_full == '0) plen_full = LEN_W'(1);
    if (plen_full > LEN_W'(PAT_CAP)) plen_full = LEN_W'(PAT_CAP);
    rlen_full = cfg_i.replacement_length;
    if (rlen_full > LEN_W'(REP_CAP)) rlen_full = LEN_W'(REP_CAP);
  end
  assign plen = CW'(plen_full);
  assign rlen = RW'(rlen_full);

  assign app_cnt = (count_q >= plen) ? '0 : count_q;
  assign app_idx = IW'(app_cnt);

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < PAT_CAP; i++) begin
      if ((CW'(i) < count_q) && (win_q[i] != cfg_i.pattern[8*i +: 8])) prefix = 1'b0;
    end
  end

  assign rep_sel  = 4'(rep_idx_q);
  assign rep_byte = cfg_i.replacement[{rep_sel, 3'b000} +: 8];
  assign emit     = cmd_i.emit_window || cmd_i.emit_repl;
  assign new_byte = cmd_i.emit_repl ? rep_byte : win_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && byte_present_i) begin
      win_q[app_idx] <= in_byte_i;
    end else if (cmd_i.emit_window) begin
      for (int i = 0; i < PAT_CAP - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rep_idx_q <= '0;
      end_q     <= 1'b0;
    end else begin
      if (pat_wr_i) begin
        count_q <= '0;
      end else if (cmd_i.load && byte_present_i) begin
        count_q <= app_cnt + CW'(1);
      end else if (cmd_i.emit_window) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.load) begin
        rep_idx_q <= '0;
        end_q     <= end_of_stream_i;
      end else if (cmd_i.emit_repl) begin
        rep_idx_q <= rep_idx_q + RW'(1);
      end
    end
  end

  // newest word waits in the hold stage until we know whether it ends the run
  assign out_free  = !out_vld_q || out_ready_i;
  assign push_hold = emit && hold_vld_q;
  assign push_last = cmd_i.finish && (hold_vld_q || end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= push_hold || push_last || (out_vld_q && !out_ready_i);
      if (emit) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) hold_byte_q <= new_byte;
    if (push_hold) begin
      out_byte_o    <= hold_byte_q;
      has_byte_o    <= 1'b1;
      run_last_o    <= 1'b0;
      stream_done_o <= 1'b0;
    end else if (push_last) begin
      out_byte_o    <= hold_vld_q ? hold_byte_q : 8'h00;
      has_byte_o    <= hold_vld_q;
      run_last_o    <= 1'b1;
      stream_done_o <= end_q;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    sts_o            = '0;
    sts_o.prefix     = prefix;
    sts_o.match      = (count_q == plen) && prefix;
    sts_o.count_zero = (count_q == '0);
    sts_o.repl_done  = (rep_idx_q == rlen);
    sts_o.emit_ok    = !hold_vld_q || out_free;
    sts_o.finish_ok  = !(hold_vld_q || end_q) || out_free;
    sts_o.in_present = byte_present_i;
    sts_o.in_end     = end_of_stream_i;
    sts_o.end_q      = end_q;
  end

endmodule

/* hdl/sfr_ctrl.sv */
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfr_pkg::sfr_sts_t sts_i,
  output sfr_pkg::sfr_cmd_t cmd_o
);
  import sfr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_REPL   = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] after_run;

  assign after_run = sts_i.end_q ? ST_FLUSH : ST_FINISH;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_present) begin
            state_d = ST_EVAL;
          end else if (sts_i.in_end) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_EVAL: begin
        if (sts_i.match) begin
          state_d = ST_REPL;
        end else if (!sts_i.prefix) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = after_run;
        end
      end
      ST_SHIFT: begin
        // shift front bytes out to the output until the window is a prefix again
        if (!sts_i.prefix) begin
          cmd_o.emit_window = sts_i.emit_ok;
        end else begin
          state_d = after_run;
        end
      end
      ST_REPL: begin
        if (sts_i.repl_done) begin
          cmd_o.clear = 1'b1;
          state_d     = after_run;
        end else begin
          cmd_o.emit_repl = sts_i.emit_ok;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.count_zero) begin
          cmd_o.emit_window = sts_i.emit_ok;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.finish_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/stream_find_replace_all_unit.sv */
// Stream find-and-replace: every leftmost, non-overlapping occurrence of the
// configured pattern in the byte stream is replaced by the replacement.
// in_i   : one text byte per word, or a bare end marker; end_of_stream flushes.
// out_o  : one byte per word; run_last marks the last word caused by an input
//          word, stream_done the last word of the stream (a marker word with
//          has_byte low is sent when an end word would otherwise give nothing).
// cfg_i  : register writes, always ready; write only while the unit is idle.
//          Writing any pattern register drops the bytes held in the window.
// Timing : one input word at a time. A byte is loaded and evaluated; a shift
//          run, replacement or end flush then emits its words, and a finish
//          step closes the item before the next acceptance. A bare end word
//          goes straight to the end flush; an empty word leaves the unit ready
//          at once. One word per cycle passes the hold stage unless out_o stalls.
// Finish : the last word of a run leaves the hold stage in the finish step, so
//          it shows on out_o in the cycle after that step.
// Stall  : out_o waiting holds the sequence; the output register still lets
//          the unit take the next input while a finished word waits.
// Reset  : clears the window count, the output and the registers (pattern
//          length 1, everything else zero).
module stream_find_replace_all_unit #(
  parameter int unsigned MAX_PATTERN_BYTES     = 16,
  parameter int unsigned MAX_REPLACEMENT_BYTES = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  sfr_in_if.sink    in_i,
  sfr_out_if.source out_o,
  sfr_cfg_if.sink   cfg_i
);
  import sfr_pkg::*;

  localparam int unsigned PAT_CAP =
    (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;
  localparam int unsigned REP_CAP =
    (MAX_REPLACEMENT_BYTES < REG_BYTES) ? MAX_REPLACEMENT_BYTES : REG_BYTES;

  sfr_cfg_t cfg;
  sfr_cmd_t cmd;
  sfr_sts_t sts;
  logic     pat_wr;
  logic     in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  sfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.wdata),
    .cfg_o       (cfg),
    .pat_wr_o    (pat_wr)
  );

  sfr_datapath #(
    .PAT_CAP (PAT_CAP),
    .REP_CAP (REP_CAP)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .pat_wr_i        (pat_wr),
    .in_byte_i       (in_i.in_byte),
    .byte_present_i  (in_i.byte_present),
    .end_of_stream_i (in_i.end_of_stream),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_byte_o      (out_o.out_byte),
    .has_byte_o      (out_o.has_byte),
    .run_last_o      (out_o.run_last),
    .stream_done_o   (out_o.stream_done)
  );

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

endmodule

/* hdl/sfr_checker.sv */
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_present_i,
  input logic       in_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       run_last_i,
  input logic       stream_done_i
);

  // a waiting word is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word withdrawn before it was taken");

  // the marker word is only the closing word of a stream
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> run_last_i && stream_done_i && (out_byte_i == 8'h00))
    else $error("marker word malformed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stream_done_i |-> run_last_i)
    else $error("stream end not on last word of its run");

  // an empty item leaves the unit ready at once
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_present_i && !in_end_i |=> in_ready_i)
    else $error("empty item held the unit");

endmodule

bind stream_find_replace_all_unit sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_present_i  (in_i.byte_present),
  .in_end_i      (in_i.end_of_stream),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .has_byte_i    (out_o.has_byte),
  .run_last_i    (out_o.run_last),
  .stream_done_i (out_o.stream_done)
);
